FILE: design/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// Used by cbm_decode and cartridge_bank_mapper; depends on nothing else.
package cbm_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_ROM_READ  = 3'd0,
        KIND_RAM_READ  = 3'd1,
        KIND_RAM_WRITE = 3'd2,
        KIND_OPEN      = 3'd3,
        KIND_REG       = 3'd4,
        KIND_SYSTEM    = 3'd5
    } kind_t;

    // Configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_MAPPER_PRESENT = 2'd0;
    localparam logic [1:0] REG_ROM_BANK_COUNT = 2'd1;
    localparam logic [1:0] REG_RAM_BANK_COUNT = 2'd2;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int PHYS_W  = 21;

    localparam logic [7:0] OPEN_BUS_BYTE = 8'hFF;
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [20:0] mem_address;
        logic [7:0]  mem_data;
    } rsp_item_t;

    typedef struct packed {
        logic       mapper_present;
        logic [7:0] rom_bank_count;
        logic [2:0] ram_bank_count;
    } cfg_t;

    typedef struct packed {
        logic       ram_enabled;
        logic [4:0] low_rom_bank;
        logic [1:0] upper_bank_bits;
        logic       advanced_mode;
    } map_state_t;

endpackage

FILE: design/cbm_decode.sv
// Address decode and bank mapping for one bus access, plus next mapper state.
// Depends on cbm_pkg.
module cbm_decode #(
    parameter int ROM_ADDRESS_BITS = 21
) (
    input  cbm_pkg::req_item_t  item,
    input  cbm_pkg::cfg_t       cfg,
    input  cbm_pkg::map_state_t state,
    output cbm_pkg::rsp_item_t  result,
    output cbm_pkg::map_state_t state_next
);

    logic [21:0] size_mask;
    logic [21:0] bus_mask;
    logic [20:0] rom_mask;
    logic [20:0] addr_ext;
    logic [20:0] rom_phys;
    logic [20:0] ram_phys;
    logic [7:0]  count_m1;
    logic [4:0]  bank_sel;
    logic        ram_access_ok;

    // Size mask wraps to all ones for a zero bank count
    assign size_mask = {cfg.rom_bank_count, 14'd0} - 22'd1;
    assign bus_mask  = (22'd1 << ROM_ADDRESS_BITS) - 22'd1;
    assign rom_mask  = size_mask[20:0] & bus_mask[20:0];
    assign addr_ext  = {5'd0, item.address};
    assign count_m1  = cfg.rom_bank_count - 8'd1;
    assign bank_sel  = item.write_data[4:0] & count_m1[4:0];
    assign ram_access_ok = state.ram_enabled && (cfg.ram_bank_count != 3'd0);

    always_comb
    begin
        if (!cfg.mapper_present)
        begin
            rom_phys = addr_ext;
        end
        else if (!item.address[14])
        begin
            rom_phys = {state.advanced_mode ? state.upper_bank_bits : 2'd0,
                        5'd0, item.address[13:0]};
        end
        else
        begin
            rom_phys = {state.upper_bank_bits, state.low_rom_bank, item.address[13:0]};
        end
    end

    always_comb
    begin
        ram_phys = {8'd0, item.address[12:0]};
        if (state.advanced_mode && cfg.ram_bank_count[2])
        begin
            ram_phys[14:13] = state.upper_bank_bits;
        end
    end

    always_comb
    begin
        state_next = state;
        result.kind        = cbm_pkg::KIND_SYSTEM;
        result.mem_address = addr_ext;
        result.mem_data    = item.action ? item.write_data : 8'd0;

        if (!item.address[15])
        begin
            if (!cfg.mapper_present && item.action)
            begin
                result.kind     = cbm_pkg::KIND_OPEN;
                result.mem_data = 8'd0;
            end
            else if (item.action)
            begin
                result.kind = cbm_pkg::KIND_REG;
                case (item.address[14:13])
                    2'd0:
                    begin
                        state_next.ram_enabled =
                            (item.write_data[3:0] == cbm_pkg::RAM_ENABLE_KEY);
                    end
                    2'd1:
                    begin
                        state_next.low_rom_bank = (bank_sel == 5'd0) ? 5'd1 : bank_sel;
                    end
                    2'd2:
                    begin
                        state_next.upper_bank_bits = item.write_data[1:0];
                    end
                    default:
                    begin
                        state_next.advanced_mode = item.write_data[0];
                    end
                endcase
            end
            else
            begin
                result.kind        = cbm_pkg::KIND_ROM_READ;
                result.mem_address = rom_phys & rom_mask;
                result.mem_data    = 8'd0;
            end
        end
        else if (item.address[15:13] == 3'b101)
        begin
            if (!ram_access_ok)
            begin
                result.kind     = cbm_pkg::KIND_OPEN;
                result.mem_data = item.action ? 8'd0 : cbm_pkg::OPEN_BUS_BYTE;
            end
            else if (item.action)
            begin
                result.kind        = cbm_pkg::KIND_RAM_WRITE;
                result.mem_address = ram_phys;
            end
            else
            begin
                result.kind        = cbm_pkg::KIND_RAM_READ;
                result.mem_address = ram_phys;
            end
        end
    end

endmodule

FILE: design/cartridge_bank_mapper.sv
// Top level of the cartridge bank mapper: config port, mapper state, output skid.
// Depends on cbm_pkg and cbm_decode.
//
//   channel  | direction | handshake          | payload
//   req      | in        | req_valid/req_stall | cbm_pkg::req_item_t
//   rsp      | out       | rsp_valid/rsp_stall | cbm_pkg::rsp_item_t
//   apb      | in/out    | psel/penable/pready | paddr, pwdata, prdata
//
// One item per cycle while req_stall is low. The mapping is one decode pass from
// the accepted item into out_reg, or into skid_reg while rsp is stalled.
// A second result register absorbs one item while rsp is stalled; req_stall is
// high only while that register holds an item.
// Reset restores config and mapper registers and empties both result registers.
module cartridge_bank_mapper #(
    parameter int ROM_ADDRESS_BITS = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  cbm_pkg::req_item_t            req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output cbm_pkg::rsp_item_t            rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbm_pkg::PADDR_W-1:0]   paddr,
    input  logic [cbm_pkg::PDATA_W-1:0]   pwdata,
    output logic [cbm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    cbm_pkg::cfg_t       cfg_reg;
    cbm_pkg::map_state_t state_reg;
    cbm_pkg::map_state_t state_next;
    cbm_pkg::rsp_item_t  result;
    cbm_pkg::rsp_item_t  out_reg;
    cbm_pkg::rsp_item_t  skid_reg;
    logic                out_valid_reg;
    logic                skid_valid_reg;
    logic                accept;
    logic                out_free;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    cbm_decode #(
        .ROM_ADDRESS_BITS(ROM_ADDRESS_BITS)
    ) u_decode (
        .item       (req),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .result     (result),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mapper_present <= 1'b1;
            cfg_reg.rom_bank_count <= 8'd2;
            cfg_reg.ram_bank_count <= 3'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                cbm_pkg::REG_MAPPER_PRESENT: cfg_reg.mapper_present <= pwdata[0];
                cbm_pkg::REG_ROM_BANK_COUNT: cfg_reg.rom_bank_count <= pwdata[7:0];
                cbm_pkg::REG_RAM_BANK_COUNT: cfg_reg.ram_bank_count <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            cbm_pkg::REG_MAPPER_PRESENT: prdata = {31'd0, cfg_reg.mapper_present};
            cbm_pkg::REG_ROM_BANK_COUNT: prdata = {24'd0, cfg_reg.rom_bank_count};
            cbm_pkg::REG_RAM_BANK_COUNT: prdata = {29'd0, cfg_reg.ram_bank_count};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.ram_enabled     <= 1'b0;
            state_reg.low_rom_bank    <= 5'd1;
            state_reg.upper_bank_bits <= 2'd0;
            state_reg.advanced_mode   <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Result registers: out_reg drives rsp, skid_reg holds one item during a stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        if (!out_free && accept)
        begin
            skid_reg <= result;
        end
    end

`ifndef SYNTH
    a_low_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.low_rom_bank != 5'd0)
        else $error("low ROM bank register holds zero");

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> rsp_valid)
        else $error("accepted item produced no result");

    a_stall_keeps_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && rsp_stall) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid item lost during output stall");
`endif

endmodule
